/* hw/rtl/pmsp_pkg.sv */
// ----------------------------------------------------------------------------
// pmsp_pkg
// Shared types and character codes for the permission mode spec parser.
// ----------------------------------------------------------------------------
package pmsp_pkg;

  localparam int unsigned MODE_W = 12;
  localparam int unsigned PERM_W = 9;

  localparam logic [MODE_W-1:0] MODE_MAX  = 12'o7777;
  localparam logic [PERM_W-1:0] PERM_ALL  = 9'o777;
  localparam logic [PERM_W-1:0] WHO_USR   = 9'o700;
  localparam logic [PERM_W-1:0] WHO_GRP   = 9'o070;
  localparam logic [PERM_W-1:0] WHO_OTH   = 9'o007;
  localparam logic [PERM_W-1:0] PERM_READ = 9'o444;
  localparam logic [PERM_W-1:0] PERM_WRT  = 9'o222;
  localparam logic [PERM_W-1:0] PERM_EXEC = 9'o111;

  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D1    = 8'h31;
  localparam logic [7:0] CH_D2    = 8'h32;
  localparam logic [7:0] CH_D3    = 8'h33;
  localparam logic [7:0] CH_D4    = 8'h34;
  localparam logic [7:0] CH_D5    = 8'h35;
  localparam logic [7:0] CH_D6    = 8'h36;
  localparam logic [7:0] CH_D7    = 8'h37;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_W     = 8'h77;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_SET = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CLS_USR = 2'd0,
    CLS_GRP = 2'd1,
    CLS_OTH = 2'd2
  } cls_t;

  typedef enum logic [2:0] {
    PH_EMPTY = 3'b001,
    PH_WHO   = 3'b010,
    PH_OP    = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0]        char_code;
    logic              begin_req;
    logic [MODE_W-1:0] start_mode;
    logic              end_marker;
  } in_item_t;

  typedef struct packed {
    logic [MODE_W-1:0] final_mode;
    logic              ok;
    logic              changed;
  } out_item_t;

  typedef struct packed {
    logic              is_digit;
    logic [2:0]        digit;
    logic [PERM_W-1:0] who;
    logic              is_op;
    op_t               op;
    logic              is_comma;
    logic              is_perm;
    logic [PERM_W-1:0] perm;
    logic              is_ref;
    cls_t              ref_cls;
  } dec_t;

endpackage

/* hw/rtl/permission_mode_spec_parser_top.sv */
// ----------------------------------------------------------------------------
// permission_mode_spec_parser_top
// Symbolic or octal permission mode parser, one character per transfer.
// ----------------------------------------------------------------------------
// an end transfer passes the input register, then its result loads the output register
// throughput: one transfer per cycle while no end transfer stalls
// an end transfer stalls only while the output register holds a result not yet taken
// reset: synchronous active-low rst_n clears old mode and work mode to zero, sets
// the parse state to empty and empties both the input and output registers
module permission_mode_spec_parser_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pmsp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pmsp_pkg::out_item_t out_data
);

  logic                s1_valid_r, s1_valid_nxt;
  pmsp_pkg::in_item_t  s1_item_r;
  logic                out_valid_r, out_valid_nxt;
  pmsp_pkg::out_item_t out_data_r;
  pmsp_pkg::dec_t      dec;
  pmsp_pkg::out_item_t res;
  logic                advance, load_out;

  pmsp_decode u_decode (
    .char_code (s1_item_r.char_code),
    .dec       (dec)
  );

  pmsp_parse u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (s1_item_r),
    .dec   (dec),
    .res   (res)
  );

  assign load_out = s1_valid_r && s1_item_r.end_marker && (!out_valid_r || out_ready);
  assign advance  = s1_valid_r && (!s1_item_r.end_marker || load_out);
  assign in_ready = !s1_valid_r || advance;

  always_comb begin
    s1_valid_nxt  = in_ready ? in_valid : s1_valid_r;
    out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
    if (load_out) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/pmsp_decode.sv */
// ----------------------------------------------------------------------------
// pmsp_decode
// Classifies one mode string character into digit, who, operator and
// permission codes.
// ----------------------------------------------------------------------------
module pmsp_decode (
  input  logic [7:0]    char_code,
  output pmsp_pkg::dec_t dec
);

  always_comb begin
    dec          = '0;
    dec.op       = pmsp_pkg::OP_ADD;
    dec.ref_cls  = pmsp_pkg::CLS_USR;
    dec.digit    = char_code[2:0];
    unique case (char_code)
      pmsp_pkg::CH_D0, pmsp_pkg::CH_D1, pmsp_pkg::CH_D2, pmsp_pkg::CH_D3,
      pmsp_pkg::CH_D4, pmsp_pkg::CH_D5, pmsp_pkg::CH_D6, pmsp_pkg::CH_D7: begin
        dec.is_digit = 1'b1;
      end
      pmsp_pkg::CH_U: begin
        dec.who     = pmsp_pkg::WHO_USR;
        dec.is_ref  = 1'b1;
        dec.ref_cls = pmsp_pkg::CLS_USR;
      end
      pmsp_pkg::CH_G: begin
        dec.who     = pmsp_pkg::WHO_GRP;
        dec.is_ref  = 1'b1;
        dec.ref_cls = pmsp_pkg::CLS_GRP;
      end
      pmsp_pkg::CH_O: begin
        dec.who     = pmsp_pkg::WHO_OTH;
        dec.is_ref  = 1'b1;
        dec.ref_cls = pmsp_pkg::CLS_OTH;
      end
      pmsp_pkg::CH_A: begin
        dec.who = pmsp_pkg::PERM_ALL;
      end
      pmsp_pkg::CH_PLUS: begin
        dec.is_op = 1'b1;
        dec.op    = pmsp_pkg::OP_ADD;
      end
      pmsp_pkg::CH_MINUS: begin
        dec.is_op = 1'b1;
        dec.op    = pmsp_pkg::OP_SUB;
      end
      pmsp_pkg::CH_EQ: begin
        dec.is_op = 1'b1;
        dec.op    = pmsp_pkg::OP_SET;
      end
      pmsp_pkg::CH_COMMA: begin
        dec.is_comma = 1'b1;
      end
      pmsp_pkg::CH_R: begin
        dec.is_perm = 1'b1;
        dec.perm    = pmsp_pkg::PERM_READ;
      end
      pmsp_pkg::CH_W: begin
        dec.is_perm = 1'b1;
        dec.perm    = pmsp_pkg::PERM_WRT;
      end
      pmsp_pkg::CH_X: begin
        dec.is_perm = 1'b1;
        dec.perm    = pmsp_pkg::PERM_EXEC;
      end
      // setuid, setgid and sticky fall outside the who mask
      pmsp_pkg::CH_S, pmsp_pkg::CH_T: begin
        dec.is_perm = 1'b1;
      end
      default: begin
        dec.is_digit = 1'b0;
      end
    endcase
  end

endmodule

/* hw/rtl/pmsp_parse.sv */
// ----------------------------------------------------------------------------
// pmsp_parse
// Parse state for one mode string: octal tracking, clause building and the
// working mode, with the result formed on the end item.
// ----------------------------------------------------------------------------
module pmsp_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  pmsp_pkg::in_item_t   item,
  input  pmsp_pkg::dec_t       dec,
  output pmsp_pkg::out_item_t  res
);

  logic [pmsp_pkg::MODE_W-1:0] old_r, old_nxt, work_r, work_nxt;
  logic [pmsp_pkg::PERM_W-1:0] who_r, who_nxt, perm_r, perm_nxt;
  pmsp_pkg::op_t               op_r, op_nxt;
  pmsp_pkg::phase_t            phase_r, phase_nxt;
  logic                        err_r, err_nxt;
  logic [pmsp_pkg::MODE_W-1:0] octv_r, octv_nxt;
  logic                        octok_r, octok_nxt;
  logic                        any_r, any_nxt;

  logic [pmsp_pkg::MODE_W-1:0] old_b, work_b, closed_work, res_mode;
  logic [pmsp_pkg::PERM_W-1:0] who_b, perm_b;
  pmsp_pkg::op_t               op_b;
  pmsp_pkg::phase_t            phase_b;
  logic                        err_b, octok_b, any_b, close_err, oct_res, ok;
  logic [pmsp_pkg::MODE_W-1:0] octv_b;
  logic [pmsp_pkg::MODE_W+2:0] oct_shift;
  logic [2:0]                  ref_src;

  function automatic logic [pmsp_pkg::MODE_W-1:0] merge_clause(
    input logic [pmsp_pkg::MODE_W-1:0] wm,
    input logic [pmsp_pkg::PERM_W-1:0] who,
    input logic [pmsp_pkg::PERM_W-1:0] perm,
    input pmsp_pkg::op_t               op
  );
    logic [pmsp_pkg::PERM_W-1:0] w;
    logic [pmsp_pkg::MODE_W-1:0] m, wx;
    w  = (who == '0) ? pmsp_pkg::PERM_ALL : who;
    m  = {3'b000, perm & w};
    wx = {3'b000, w};
    case (op)
      pmsp_pkg::OP_SUB: merge_clause = wm & ~m;
      pmsp_pkg::OP_SET: merge_clause = (wm & ~wx) | m;
      default:          merge_clause = wm | m;
    endcase
  endfunction

  always_comb begin
    // begin loads the old mode and clears the parse
    old_b   = item.begin_req ? item.start_mode : old_r;
    work_b  = item.begin_req ? item.start_mode : work_r;
    who_b   = item.begin_req ? '0 : who_r;
    perm_b  = item.begin_req ? '0 : perm_r;
    op_b    = item.begin_req ? pmsp_pkg::OP_ADD : op_r;
    phase_b = item.begin_req ? pmsp_pkg::PH_EMPTY : phase_r;
    err_b   = item.begin_req ? 1'b0 : err_r;
    octv_b  = item.begin_req ? '0 : octv_r;
    octok_b = item.begin_req ? 1'b0 : octok_r;
    any_b   = item.begin_req ? 1'b0 : any_r;

    close_err   = (phase_b == pmsp_pkg::PH_WHO);
    closed_work = (phase_b == pmsp_pkg::PH_OP) ?
                  merge_clause(work_b, who_b, perm_b, op_b) : work_b;

    oct_shift = {octv_b, 3'b000} | {12'd0, dec.digit};
    unique case (dec.ref_cls)
      pmsp_pkg::CLS_GRP: ref_src = work_b[5:3];
      pmsp_pkg::CLS_OTH: ref_src = work_b[2:0];
      default:           ref_src = work_b[8:6];
    endcase

    oct_res  = any_b & octok_b;
    ok       = oct_res | ~(err_b | close_err);
    res_mode = oct_res ? octv_b : (ok ? closed_work : old_b);
    res.final_mode = res_mode;
    res.ok         = ok;
    res.changed    = ok && (res_mode != old_b);

    old_nxt   = old_b;
    work_nxt  = work_b;
    who_nxt   = who_b;
    perm_nxt  = perm_b;
    op_nxt    = op_b;
    phase_nxt = phase_b;
    err_nxt   = err_b;
    octv_nxt  = octv_b;
    octok_nxt = octok_b;
    any_nxt   = any_b;

    if (item.end_marker) begin
      work_nxt  = old_b;
      who_nxt   = '0;
      perm_nxt  = '0;
      op_nxt    = pmsp_pkg::OP_ADD;
      phase_nxt = pmsp_pkg::PH_EMPTY;
      err_nxt   = 1'b0;
      octv_nxt  = '0;
      octok_nxt = 1'b0;
      any_nxt   = 1'b0;
    end else begin
      // octal tracking
      if (!any_b) begin
        octok_nxt = dec.is_digit;
        octv_nxt  = dec.is_digit ? {9'd0, dec.digit} : '0;
      end else if (octok_b) begin
        if (!dec.is_digit || (oct_shift[pmsp_pkg::MODE_W+2:pmsp_pkg::MODE_W] != 3'd0)) begin
          octok_nxt = 1'b0;
        end else begin
          octv_nxt = oct_shift[pmsp_pkg::MODE_W-1:0];
        end
      end
      // symbolic clauses
      if (!err_b) begin
        if (dec.is_comma) begin
          err_nxt   = close_err;
          work_nxt  = closed_work;
          who_nxt   = '0;
          perm_nxt  = '0;
          op_nxt    = pmsp_pkg::OP_ADD;
          phase_nxt = pmsp_pkg::PH_EMPTY;
        end else if (phase_b != pmsp_pkg::PH_OP) begin
          priority if (dec.who != '0) begin
            who_nxt   = who_b | dec.who;
            phase_nxt = pmsp_pkg::PH_WHO;
          end else if (dec.is_op) begin
            op_nxt    = dec.op;
            phase_nxt = pmsp_pkg::PH_OP;
          end else begin
            err_nxt = 1'b1;
          end
        end else begin
          priority if (dec.is_perm) begin
            perm_nxt = perm_b | dec.perm;
          end else if (dec.is_ref) begin
            perm_nxt = perm_b | {3{ref_src}};
          end else begin
            err_nxt = 1'b1;
          end
        end
      end
      any_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      old_r   <= '0;
      work_r  <= '0;
      who_r   <= '0;
      perm_r  <= '0;
      op_r    <= pmsp_pkg::OP_ADD;
      phase_r <= pmsp_pkg::PH_EMPTY;
      err_r   <= 1'b0;
      octv_r  <= '0;
      octok_r <= 1'b0;
      any_r   <= 1'b0;
    end else if (step) begin
      old_r   <= old_nxt;
      work_r  <= work_nxt;
      who_r   <= who_nxt;
      perm_r  <= perm_nxt;
      op_r    <= op_nxt;
      phase_r <= phase_nxt;
      err_r   <= err_nxt;
      octv_r  <= octv_nxt;
      octok_r <= octok_nxt;
      any_r   <= any_nxt;
    end
  end

  // an end transfer leaves a cleared parse
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.end_marker) |=> (phase_r == pmsp_pkg::PH_EMPTY) && !any_r && !err_r)
    else $error("parse state not cleared after end transfer");

  // no characters yet means work mode still equals old mode
  a_idle_work: assert property (@(posedge clk) disable iff (!rst_n)
    !any_r |-> (work_r == old_r) && !octok_r && !err_r)
    else $error("work mode diverged before any character");

  // a partial clause needs at least one character
  a_phase_any: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != pmsp_pkg::PH_EMPTY) |-> any_r)
    else $error("clause phase set with no character seen");

endmodule
